@@ rtl/core/ignition_power_sequencer_top_defines.svh @@
// Assertion macros shared by the ignition power sequencer RTL.
`ifndef IGNITION_POWER_SEQUENCER_TOP_DEFINES_SVH
`define IGNITION_POWER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define IPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ignition sequencer: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define IPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ignition sequencer: next-cycle check failed");

`endif

@@ rtl/core/ips_pkg.sv @@
// Types, constants and helpers of the ignition power sequencer.
package ips_pkg;

    localparam int WINDOW_DEPTH = 4;
    localparam int CODE_W       = 10;
    localparam int SUM_W        = CODE_W + $clog2(WINDOW_DEPTH);
    localparam int LIMIT_W      = 12;
    localparam int CMP_W        = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam int RETRY_W      = 8;
    localparam int START_W      = 10;
    localparam int STEP_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CODE_W-1:0]  RST_IGN_LIMIT  = 10'd634;
    localparam logic [LIMIT_W-1:0] RST_LAMP_LIMIT = 12'd738;
    localparam logic [RETRY_W-1:0] RST_MAX_RETRY  = 8'd50;
    localparam logic [START_W-1:0] RST_START_WAIT = 10'd200;
    localparam logic [STEP_W-1:0]  RST_SHUT_HOLD  = 16'd75;

    typedef enum logic [3:0] {
        PH_IDLE_WAIT      = 4'd0,
        PH_IDLE_CONFIRM   = 4'd1,
        PH_START_DROP     = 4'd2,
        PH_START_CHECK    = 4'd3,
        PH_START_SECOND   = 4'd4,
        PH_START_VERIFY   = 4'd5,
        PH_START_COMPLETE = 4'd6,
        PH_RUN            = 4'd7,
        PH_RUN_CONFIRM    = 4'd8,
        PH_SHUT           = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_SHUT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IGN_LIMIT  = 3'd0,
        CFG_LAMP_LIMIT = 3'd1,
        CFG_MAX_RETRY  = 3'd2,
        CFG_START_WAIT = 3'd3,
        CFG_SHUT_HOLD  = 3'd4,
        CFG_INVERT     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic led;
        logic lamp;
        logic shut;
        logic relay;
    } t_pins;

    typedef struct packed {
        logic [CODE_W-1:0] ign_code;
        logic [CODE_W-1:0] ill_code;
    } t_in_item;

    typedef struct packed {
        logic       relay_out;
        logic       shut_out;
        logic       lamp_out;
        logic       led_out;
        logic [1:0] mode_out;
    } t_out_item;

    function automatic t_mode phase_mode(t_phase ph);
        t_mode m;
        case (ph)
            PH_IDLE_WAIT, PH_IDLE_CONFIRM: m = MODE_IDLE;
            PH_START_DROP, PH_START_CHECK, PH_START_SECOND,
            PH_START_VERIFY, PH_START_COMPLETE: m = MODE_START;
            PH_RUN, PH_RUN_CONFIRM: m = MODE_RUN;
            PH_SHUT: m = MODE_SHUT;
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/ignition_power_sequencer_top.sv @@
// Top level of the ignition power sequencer: config, mode FSM and result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in_data  (ign_code, ill_code)
//  out     | source    | o_out_valid / i_out_ready | o_out_data (relay, shut, lamp, led, mode)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_ready holds; its result appears in the output register in the
// cycle after acceptance; FSM step, window update and lamp compare settle before that register.
// The input stays ready while the output register is empty or is being taken this cycle.
// The config port is always ready. Synchronous active-low reset restores all register
// defaults, the idle phase, a zero window and all pins off.
`include "ignition_power_sequencer_top_defines.svh"

module ignition_power_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ips_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ips_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ips_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ips_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [ips_pkg::CODE_W-1:0]  r_ign_limit;
    logic [ips_pkg::LIMIT_W-1:0] r_lamp_limit;
    logic [ips_pkg::RETRY_W-1:0] r_max_retry;
    logic [ips_pkg::START_W-1:0] r_start_wait;
    logic [ips_pkg::STEP_W-1:0]  r_shut_hold;
    logic                        r_invert;

    // sequencer state
    ips_pkg::t_phase             r_phase, n_phase;
    logic [ips_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        r_blink, n_blink;
    ips_pkg::t_pins              r_pins, n_pins;

    // result register
    logic                        r_out_valid;
    ips_pkg::t_out_item          r_out_data, n_out_data;

    logic                        in_accept;
    logic                        ign_on;
    logic [ips_pkg::STEP_W-1:0]  step_inc;
    logic                        retry_done;
    logic                        start_done;
    logic                        hold_done;
    logic                        no_start_wait;
    logic                        win_shift;
    logic                        lamp_on;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    // ignition off is simply "not on"
    assign ign_on        = i_in_data.ign_code > r_ign_limit;
    assign step_inc      = r_step + 1'b1;
    // a zero retry budget still ends after one sample
    assign retry_done    = step_inc >= ips_pkg::STEP_W'(r_max_retry);
    assign start_done    = step_inc >= ips_pkg::STEP_W'(r_start_wait);
    assign hold_done     = r_step >= r_shut_hold;
    assign no_start_wait = r_start_wait == '0;

    ips_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (in_accept && win_shift),
        .i_code    (i_in_data.ill_code),
        .i_limit   (r_lamp_limit),
        .o_lamp_on (lamp_on)
    );

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            ips_pkg::PH_IDLE_CONFIRM: begin
                n_phase = ign_on ? ips_pkg::PH_START_DROP : ips_pkg::PH_IDLE_WAIT;
            end
            ips_pkg::PH_START_DROP: begin
                if (retry_done) begin
                    n_phase = ips_pkg::PH_START_CHECK;
                end else if (!ign_on) begin
                    n_phase = ips_pkg::PH_START_SECOND;
                end
            end
            ips_pkg::PH_START_CHECK: begin
                if (ign_on) begin
                    n_phase = no_start_wait ? ips_pkg::PH_RUN : ips_pkg::PH_START_COMPLETE;
                end else begin
                    n_phase = ips_pkg::PH_START_DROP;
                end
            end
            ips_pkg::PH_START_SECOND: begin
                if (retry_done || ign_on) begin
                    n_phase = ips_pkg::PH_START_VERIFY;
                end
            end
            ips_pkg::PH_START_VERIFY: begin
                if (ign_on) begin
                    n_phase = no_start_wait ? ips_pkg::PH_RUN : ips_pkg::PH_START_COMPLETE;
                end else begin
                    n_phase = ips_pkg::PH_IDLE_WAIT;
                end
            end
            ips_pkg::PH_START_COMPLETE: begin
                if (start_done) begin
                    n_phase = ips_pkg::PH_RUN;
                end
            end
            ips_pkg::PH_RUN: begin
                if (!ign_on) begin
                    n_phase = ips_pkg::PH_RUN_CONFIRM;
                end
            end
            ips_pkg::PH_RUN_CONFIRM: begin
                n_phase = ign_on ? ips_pkg::PH_RUN : ips_pkg::PH_SHUT;
            end
            ips_pkg::PH_SHUT: begin
                if (hold_done) begin
                    n_phase = ips_pkg::PH_IDLE_WAIT;
                end
            end
            default: begin
                // idle wait, and any unused code, looks for a first ignition
                n_phase = ign_on ? ips_pkg::PH_IDLE_CONFIRM : ips_pkg::PH_IDLE_WAIT;
            end
        endcase
    end

    // counter, blink and pin levels
    always_comb begin
        n_step    = r_step;
        n_blink   = r_blink;
        n_pins    = r_pins;
        win_shift = 1'b0;
        case (r_phase)
            ips_pkg::PH_IDLE_CONFIRM: begin
                if (ign_on) begin
                    n_step = '0;
                end
            end
            ips_pkg::PH_START_DROP: begin
                // toggle the LED each sample, drop it on the ending sample
                n_blink    = !r_blink;
                n_pins.led = !r_blink;
                n_step     = step_inc;
                if (retry_done) begin
                    n_pins.led = 1'b0;
                end else if (!ign_on) begin
                    n_pins.led = 1'b0;
                    n_step     = '0;
                end
            end
            ips_pkg::PH_START_CHECK: begin
                n_step = '0;
                if (ign_on) begin
                    n_pins.relay = 1'b1;
                end
            end
            ips_pkg::PH_START_SECOND: begin
                n_pins.led = !(retry_done || ign_on);
                n_step     = step_inc;
            end
            ips_pkg::PH_START_VERIFY: begin
                if (ign_on) begin
                    n_pins.relay = 1'b1;
                    n_step       = '0;
                end
            end
            ips_pkg::PH_START_COMPLETE: begin
                n_pins.relay = 1'b1;
                n_pins.lamp  = lamp_on;
                win_shift    = 1'b1;
                n_step       = step_inc;
            end
            ips_pkg::PH_RUN: begin
                n_pins.relay = 1'b1;
                n_pins.lamp  = lamp_on;
                win_shift    = 1'b1;
            end
            ips_pkg::PH_RUN_CONFIRM: begin
                if (!ign_on) begin
                    n_pins.led  = 1'b1;
                    n_pins.shut = 1'b1;
                    n_step      = '0;
                end
            end
            ips_pkg::PH_SHUT: begin
                if (hold_done) begin
                    n_pins = '0;
                    n_step = '0;
                end else begin
                    n_step = step_inc;
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    // result fields after this sample; LED is never inverted
    always_comb begin
        n_out_data.relay_out = n_pins.relay ^ r_invert;
        n_out_data.shut_out  = n_pins.shut ^ r_invert;
        n_out_data.lamp_out  = n_pins.lamp ^ r_invert;
        n_out_data.led_out   = n_pins.led;
        n_out_data.mode_out  = ips_pkg::phase_mode(n_phase);
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign_limit  <= ips_pkg::RST_IGN_LIMIT;
            r_lamp_limit <= ips_pkg::RST_LAMP_LIMIT;
            r_max_retry  <= ips_pkg::RST_MAX_RETRY;
            r_start_wait <= ips_pkg::RST_START_WAIT;
            r_shut_hold  <= ips_pkg::RST_SHUT_HOLD;
            r_invert     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (ips_pkg::t_cfg_idx'(i_cfg_index))
                ips_pkg::CFG_IGN_LIMIT:  r_ign_limit  <= i_cfg_data[ips_pkg::CODE_W-1:0];
                ips_pkg::CFG_LAMP_LIMIT: r_lamp_limit <= i_cfg_data[ips_pkg::LIMIT_W-1:0];
                ips_pkg::CFG_MAX_RETRY:  r_max_retry  <= i_cfg_data[ips_pkg::RETRY_W-1:0];
                ips_pkg::CFG_START_WAIT: r_start_wait <= i_cfg_data[ips_pkg::START_W-1:0];
                ips_pkg::CFG_SHUT_HOLD:  r_shut_hold  <= i_cfg_data[ips_pkg::STEP_W-1:0];
                ips_pkg::CFG_INVERT:     r_invert     <= i_cfg_data[0];
                default: begin
                    r_invert <= r_invert;
                end
            endcase
        end
    end

    // advance the sequencer on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ips_pkg::PH_IDLE_WAIT;
            r_step  <= '0;
            r_blink <= 1'b0;
            r_pins  <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_blink <= n_blink;
            r_pins  <= n_pins;
        end
    end

    // hold the result until taken, load a new one on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `IPS_ASSERT_NEXT(a_accept_gives_result, in_accept, o_out_valid)
    `IPS_ASSERT_NEXT(a_idle_holds_phase, !in_accept, $stable(r_phase) && $stable(r_step))
    `IPS_ASSERT_NOW(a_run_relay_on, r_phase == ips_pkg::PH_RUN || r_phase == ips_pkg::PH_RUN_CONFIRM, r_pins.relay)
    `IPS_ASSERT_NOW(a_shut_request_on, r_phase == ips_pkg::PH_SHUT, r_pins.shut && r_pins.led)
    `IPS_ASSERT_NOW(a_idle_released, r_phase == ips_pkg::PH_IDLE_WAIT, !r_pins.relay && !r_pins.shut)

endmodule

@@ rtl/core/ips_window.sv @@
// Illumination sample window with running sum and lamp threshold compare.
module ips_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_shift,
    input  logic [ips_pkg::CODE_W-1:0]       i_code,
    input  logic [ips_pkg::LIMIT_W-1:0]      i_limit,
    output logic                             o_lamp_on
);

    logic [ips_pkg::CODE_W-1:0] r_win [ips_pkg::WINDOW_DEPTH];
    logic [ips_pkg::SUM_W-1:0]  r_sum;
    logic [ips_pkg::SUM_W-1:0]  n_sum;

    // add the newest sample, drop the oldest
    assign n_sum = r_sum + ips_pkg::SUM_W'(i_code)
                 - ips_pkg::SUM_W'(r_win[ips_pkg::WINDOW_DEPTH-1]);

    assign o_lamp_on = ips_pkg::CMP_W'(n_sum) < ips_pkg::CMP_W'(i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int k = 0; k < ips_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_shift) begin
            r_sum    <= n_sum;
            r_win[0] <= i_code;
            for (int k = 1; k < ips_pkg::WINDOW_DEPTH; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

endmodule
